// ===== src/nlpb_pkg.sv =====
// Shared types and constants of the next-line prefetch buffer.
// Used by nlpb_ctrl, nlpb_dp and next_line_prefetch_buffer; no dependencies.
package nlpb_pkg;

    localparam int HIT_BITS   = 16;
    localparam int STAT_BITS  = 32;
    localparam int OFS_BITS   = 13;
    localparam int APB_DATA   = 32;
    localparam int APB_ADDR   = 3;

    localparam logic [HIT_BITS-1:0] HITS_MAX     = '1;
    localparam logic [OFS_BITS-1:0] OFS_RESET    = 13'd64;
    localparam logic [APB_ADDR-1:0] REG_OFS_ADDR = 3'd0;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_FILL   = 2'd1,
        OP_INVAL  = 2'd2,
        OP_DEMAND = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_APPLY,
        S_SCAN,
        S_EVICT,
        S_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic match;
        logic apply;
        logic scan_start;
        logic scan_step;
        logic evict;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic any_match;
        logic full;
        logic is_fill;
        logic scan_last;
        logic out_free;
    } sts_t;

endpackage

// ===== src/next_line_prefetch_buffer.sv =====
// Next-line prefetch buffer with least-hit replacement (top level).
// A beat passes through the match, apply and finish states; a fill into a full buffer
// also runs the one-entry-per-cycle victim scan and an eviction before finish.
// A new beat is taken only when idle, once the last beat's result is handed off.
// Reset: buffer empty, counters zero, prefetch offset 64; no clearing pass.
// Depends on nlpb_pkg, nlpb_ctrl and nlpb_dp.
module next_line_prefetch_buffer #(
    parameter int ENTRIES   = 32,
    parameter int ADDR_BITS = 48
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [nlpb_pkg::APB_ADDR-1:0]  paddr,
    input  logic [nlpb_pkg::APB_DATA-1:0]  pwdata,
    output logic [nlpb_pkg::APB_DATA-1:0]  prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     operation,
    input  logic [ADDR_BITS-1:0]           address,
    input  logic                           from_prefetch,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           hit,
    output logic                           prefetch_valid,
    output logic [ADDR_BITS-1:0]           prefetch_address,
    output logic                           evicted,
    output logic [nlpb_pkg::STAT_BITS-1:0] issued_total,
    output logic [nlpb_pkg::STAT_BITS-1:0] useful_total
);
    import nlpb_pkg::*;

    cmd_t                cmd;
    sts_t                sts;
    logic                ofs_we;
    logic [OFS_BITS-1:0] ofs_value;

    // register port
    assign pready = 1'b1;
    assign ofs_we = psel && penable && pwrite && (paddr == REG_OFS_ADDR);
    assign prdata = (paddr == REG_OFS_ADDR) ? APB_DATA'(ofs_value) : '0;

    nlpb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    nlpb_dp #(
        .ENTRIES   (ENTRIES),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .operation        (operation),
        .address          (address),
        .from_prefetch    (from_prefetch),
        .ofs_we           (ofs_we),
        .ofs_wdata        (pwdata[OFS_BITS-1:0]),
        .ofs_value        (ofs_value),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .hit              (hit),
        .prefetch_valid   (prefetch_valid),
        .prefetch_address (prefetch_address),
        .evicted          (evicted),
        .issued_total     (issued_total),
        .useful_total     (useful_total)
    );

endmodule

// ===== src/nlpb_ctrl.sv =====
// Sequencer of the prefetch buffer: steps one beat through match, apply,
// victim scan, eviction and result hand-off. Depends on nlpb_pkg.
module nlpb_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  nlpb_pkg::sts_t sts,
    output nlpb_pkg::cmd_t cmd,
    output logic          in_stall
);
    import nlpb_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_MATCH;
            end
            S_MATCH:  state_next = S_APPLY;
            S_APPLY:
            begin
                if (sts.is_fill && !sts.any_match && sts.full)
                    state_next = S_SCAN;
                else
                    state_next = S_FINISH;
            end
            S_SCAN:
            begin
                if (sts.scan_last)
                    state_next = S_EVICT;
            end
            S_EVICT:  state_next = S_FINISH;
            S_FINISH:
            begin
                if (sts.out_free)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            S_MATCH:  cmd.match = 1'b1;
            S_APPLY:
            begin
                if (sts.is_fill && !sts.any_match && sts.full)
                    cmd.scan_start = 1'b1;
                else
                    cmd.apply = 1'b1;
            end
            S_SCAN:   cmd.scan_step = 1'b1;
            S_EVICT:  cmd.evict = 1'b1;
            S_FINISH: cmd.finish = sts.out_free;
            default:  cmd = '0;
        endcase
    end

endmodule

// ===== src/nlpb_dp.sv =====
// Datapath of the prefetch buffer: entry registers, parallel compare,
// victim scan, counters, offset register and output register. Uses nlpb_pkg.
module nlpb_dp #(
    parameter int ENTRIES   = 32,
    parameter int ADDR_BITS = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  nlpb_pkg::cmd_t                cmd,
    output nlpb_pkg::sts_t                sts,
    input  logic [1:0]                    operation,
    input  logic [ADDR_BITS-1:0]          address,
    input  logic                          from_prefetch,
    input  logic                          ofs_we,
    input  logic [nlpb_pkg::OFS_BITS-1:0] ofs_wdata,
    output logic [nlpb_pkg::OFS_BITS-1:0] ofs_value,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic                          hit,
    output logic                          prefetch_valid,
    output logic [ADDR_BITS-1:0]          prefetch_address,
    output logic                          evicted,
    output logic [nlpb_pkg::STAT_BITS-1:0] issued_total,
    output logic [nlpb_pkg::STAT_BITS-1:0] useful_total
);
    import nlpb_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic [ADDR_BITS-1:0] addr_reg [ENTRIES];
    logic [ADDR_BITS-1:0] addr_next [ENTRIES];
    logic [HIT_BITS-1:0]  hits_reg [ENTRIES];
    logic [HIT_BITS-1:0]  hits_next [ENTRIES];
    logic [CNT_W-1:0]     count_reg, count_next;

    op_t                  op_reg;
    logic [ADDR_BITS-1:0] in_addr_reg;
    logic                 from_pf_reg;
    logic [ENTRIES-1:0]   match_reg;
    logic                 any_match;
    logic [IDX_W-1:0]     first_pos;
    logic                 first_unused;

    logic [IDX_W-1:0]     scan_idx_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [HIT_BITS-1:0]  best_hits_reg;

    logic [STAT_BITS-1:0] issued_reg, useful_reg;
    logic [OFS_BITS-1:0]  ofs_reg;

    logic                 res_hit_reg, res_pfv_reg, res_ev_reg;
    logic [ADDR_BITS-1:0] res_pfa_reg;

    logic                 out_valid_reg;
    logic                 out_hit_reg, out_pfv_reg, out_ev_reg;
    logic [ADDR_BITS-1:0] out_pfa_reg;
    logic [STAT_BITS-1:0] out_issued_reg, out_useful_reg;

    logic                 shift_en;
    logic [IDX_W-1:0]     shift_pos;

    // first matching entry and whether the match was never hit; buffer keeps addresses unique
    always_comb
    begin
        first_pos    = '0;
        first_unused = 1'b1;
        for (int j = ENTRIES - 1; j >= 0; j--)
        begin
            if (match_reg[j])
                first_pos = IDX_W'(j);
        end
        first_unused = 1'b1;
        for (int j = 0; j < ENTRIES; j++)
        begin
            if (match_reg[j] && hits_reg[j] != '0)
                first_unused = 1'b0;
        end
    end

    assign any_match = |match_reg;

    assign sts.any_match = any_match;
    assign sts.full      = (count_reg == CNT_W'(ENTRIES));
    assign sts.is_fill   = (op_reg == OP_FILL);
    assign sts.scan_last = (scan_idx_reg == LAST_IDX);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    // removal shift: invalidate removes the match, eviction the victim
    assign shift_en  = cmd.evict || (cmd.apply && op_reg == OP_INVAL && any_match);
    assign shift_pos = cmd.evict ? best_idx_reg : first_pos;

    // entry update
    always_comb
    begin
        for (int j = 0; j < ENTRIES; j++)
        begin
            addr_next[j] = addr_reg[j];
            hits_next[j] = hits_reg[j];
        end
        count_next = count_reg;

        if (shift_en)
        begin
            for (int j = 0; j < ENTRIES - 1; j++)
            begin
                if (IDX_W'(j) >= shift_pos)
                begin
                    addr_next[j] = addr_reg[j + 1];
                    hits_next[j] = hits_reg[j + 1];
                end
            end
            if (cmd.evict)
            begin
                addr_next[ENTRIES - 1] = in_addr_reg;
                hits_next[ENTRIES - 1] = '0;
            end
            else
                count_next = count_reg - 1'b1;
        end

        if (cmd.apply && op_reg == OP_LOOKUP)
        begin
            for (int j = 0; j < ENTRIES; j++)
            begin
                if (match_reg[j] && hits_reg[j] != HITS_MAX)
                    hits_next[j] = hits_reg[j] + 1'b1;
            end
        end

        if (cmd.apply && op_reg == OP_FILL && !any_match)
        begin
            addr_next[count_reg[IDX_W-1:0]] = in_addr_reg;
            hits_next[count_reg[IDX_W-1:0]] = '0;
            count_next = count_reg + 1'b1;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < ENTRIES; j++)
        begin
            addr_reg[j] <= addr_next[j];
            hits_reg[j] <= hits_next[j];
        end
    end

    // captured beat, compare vector and scan state
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= op_t'(operation);
            in_addr_reg <= address;
            from_pf_reg <= from_prefetch;
        end
        if (cmd.match)
        begin
            for (int j = 0; j < ENTRIES; j++)
                match_reg[j] <= (addr_reg[j] == in_addr_reg) && (CNT_W'(j) < count_reg);
        end
        if (cmd.scan_start)
        begin
            scan_idx_reg  <= IDX_W'(1);
            best_idx_reg  <= '0;
            best_hits_reg <= hits_reg[0];
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            if (hits_reg[scan_idx_reg] < best_hits_reg)
            begin
                best_idx_reg  <= scan_idx_reg;
                best_hits_reg <= hits_reg[scan_idx_reg];
            end
        end
    end

    // per-beat result fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_hit_reg <= 1'b0;
            res_pfv_reg <= 1'b0;
            res_pfa_reg <= '0;
            res_ev_reg  <= 1'b0;
        end
        else if (cmd.apply)
        begin
            res_hit_reg <= (op_reg == OP_LOOKUP) && any_match;
            if (op_reg == OP_DEMAND && !from_pf_reg)
            begin
                res_pfv_reg <= 1'b1;
                res_pfa_reg <= in_addr_reg + ADDR_BITS'(ofs_reg);
            end
        end
        else if (cmd.evict)
            res_ev_reg <= 1'b1;
    end

    // control state: fill count, statistics, offset, output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            issued_reg    <= '0;
            useful_reg    <= '0;
            ofs_reg       <= OFS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (ofs_we)
                ofs_reg <= ofs_wdata;
            if (cmd.apply && op_reg == OP_DEMAND && !from_pf_reg)
                issued_reg <= issued_reg + 1'b1;
            if (cmd.apply && op_reg == OP_LOOKUP && any_match && first_unused)
                useful_reg <= useful_reg + 1'b1;
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_hit_reg    <= res_hit_reg;
            out_pfv_reg    <= res_pfv_reg;
            out_pfa_reg    <= res_pfa_reg;
            out_ev_reg     <= res_ev_reg;
            out_issued_reg <= issued_reg;
            out_useful_reg <= useful_reg;
        end
    end

    assign ofs_value        = ofs_reg;
    assign out_valid        = out_valid_reg;
    assign hit              = out_hit_reg;
    assign prefetch_valid   = out_pfv_reg;
    assign prefetch_address = out_pfa_reg;
    assign evicted          = out_ev_reg;
    assign issued_total     = out_issued_reg;
    assign useful_total     = out_useful_reg;

endmodule
